// ===== hw/rtl/ktg_pkg.sv =====
// Package: types, constants and the quarter-wave sine table of the kick trajectory generator.
package ktg_pkg;

  localparam int COS_TABLE_BITS = 10;
  localparam int ROM_N = 1 << COS_TABLE_BITS;
  localparam int ANG_W = COS_TABLE_BITS + 2;
  localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

  localparam int IN_DATA_W = 104;
  localparam int OUT_DATA_W = 216;
  localparam int CFG_DATA_W = 24;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_SHIFT  = 3'd1,
    PH_KICK   = 3'd2,
    PH_RETURN = 3'd3,
    PH_DONE   = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    CFG_SIDE_SEP    = 3'd0,
    CFG_SHIFT_TIME  = 3'd1,
    CFG_LIFT_TIME   = 3'd2,
    CFG_SWING_TIME  = 3'd3,
    CFG_RETRACT_TIME = 3'd4,
    CFG_RETURN_TIME = 3'd5,
    CFG_BACK_DIST   = 3'd6,
    CFG_KICK_HEIGHT = 3'd7
  } cfg_reg_t;

  localparam logic ACT_START = 1'b0;
  localparam logic ACT_TICK  = 1'b1;

  typedef logic [16:0] rom_t [0:ROM_N];

  function automatic logic [16:0] rom_entry(input int k);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    longint sum;
    longint r;
    x = (64'(k) * PI_HALF_Q30) >> COS_TABLE_BITS;
    x2 = (x * x) >> 30;
    term = x;
    sum = longint'(x);
    for (int n = 1; n <= 7; n++) begin
      term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
      if ((n % 2) == 1) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    r = (sum + 8192) >>> 14;
    if (r > 65536) r = 65536;
    return 17'(r);
  endfunction

  function automatic rom_t build_rom();
    rom_t t;
    for (int k = 0; k <= ROM_N; k++) t[k] = rom_entry(k);
    return t;
  endfunction

  localparam rom_t QROM = build_rom();

endpackage

// ===== hw/rtl/kick_trajectory_generator_core.sv =====
// Top level: kick trajectory generator, sequenced over one shared divider, multiplier and sine table.
//
//  channel | dir | handshake          | payload
//  in_     | in  | tvalid/tready      | tuser: action; tdata: left_kick, start_x, start_y,
//          |     |                    |   start_yaw, dt_us
//  out_    | out | tvalid/tready      | tuser: phase_code; tdata: active, torso_x/y,
//          |     |                    |   support_x/y, kick_x/y, kick_z
//  cfg_    | in  | wr_en, no wait     | index, data
//
// A start beat gives no result. A tick beat in shift, kick or return runs a 16-step
// restoring divider for the phase fraction, skipped when the fraction clamps to one;
// then table reads and products go through one shared multiplier in turn. A tick beat
// in idle or done goes straight to the output register.
// in_tready is high only while idle.
// A finished result waits in the output register; the next tick stalls only at its end.
// Reset (rst_n low, synchronous) loads the register defaults and enters idle.
module kick_trajectory_generator_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [0] left_kick, [32:1] start_x, [64:33] start_y, [80:65] start_yaw, [100:81] dt_us
  input  logic [ktg_pkg::IN_DATA_W-1:0]   in_tdata,
  // [0] action
  input  logic                            in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [0] active, [32:1] torso_x, [64:33] torso_y, [96:65] support_x, [128:97] support_y,
  // [160:129] kick_x, [192:161] kick_y, [209:193] kick_z
  output logic [ktg_pkg::OUT_DATA_W-1:0]  out_tdata,
  // [2:0] phase_code
  output logic [2:0]                      out_tuser,
  input  logic                            cfg_wr_en,
  input  logic [2:0]                      cfg_index,
  input  logic [ktg_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int CTB = ktg_pkg::COS_TABLE_BITS;
  localparam int AW  = ktg_pkg::ANG_W;

  typedef enum logic [21:0] {
    ST_IDLE  = 22'h000001,
    ST_ADD   = 22'h000002,
    ST_CMP   = 22'h000004,
    ST_FRAC  = 22'h000008,
    ST_CHK   = 22'h000010,
    ST_DIV   = 22'h000020,
    ST_PHI   = 22'h000040,
    ST_QUAD  = 22'h000080,
    ST_KP    = 22'h000100,
    ST_KP3   = 22'h000200,
    ST_SWG   = 22'h000400,
    ST_ROM   = 22'h000800,
    ST_HCOS  = 22'h001000,
    ST_MUL1  = 22'h002000,
    ST_MUL2  = 22'h004000,
    ST_MUL3  = 22'h008000,
    ST_HEADC = 22'h010000,
    ST_HEADS = 22'h020000,
    ST_ROTX  = 22'h040000,
    ST_ROTY  = 22'h080000,
    ST_ROTZ  = 22'h100000,
    ST_OUT   = 22'h200000
  } state_t;

  state_t state_r, state_nxt;

  logic [16:0] side_sep_r, back_dist_r, kick_h_r;
  logic [23:0] shift_t_r, lift_t_r, swing_t_r, retract_t_r, return_t_r;

  ktg_pkg::phase_t phase_r, ran_r;
  logic [31:0] elapsed_r;
  logic [31:0] tox_r, toy_r, koy_r, soy_r;
  logic [15:0] heading_r;

  logic [19:0] dt_r;
  logic [24:0] bc_r;
  logic [25:0] bcd_r;
  logic        lt_b_r, lt_bc_r;
  logic        swing_r, retract_r;
  logic [31:0] num_r;
  logic [23:0] len_r;
  logic [23:0] rem_r;
  logic [3:0]  cnt_r;
  logic [16:0] phi_r;
  logic        hi_r;
  logic [16:0] kp_r;
  logic [16:0] h_r;
  logic [AW-1:0] ang_r;
  logic [16:0] rom_r;
  logic        neg_r;
  logic signed [17:0] c_r, s_r;
  logic signed [17:0] ox_r;
  logic [31:0] ty_r, kx_r, ky_r;
  logic [16:0] kz_r;

  logic        out_valid_r;
  logic [ktg_pkg::OUT_DATA_W-1:0] out_data_r;
  logic [2:0]  out_user_r;

  logic signed [33:0] mul_a;
  logic signed [19:0] mul_b;
  logic signed [53:0] prod_r;

  logic        in_acc;
  logic [32:0] sum_t;
  logic [24:0] rem2;
  logic        div_bit;
  logic [CTB:0] rom_idx;
  logic signed [17:0] sval;
  logic signed [18:0] hdiff;
  logic [16:0] hsel;
  logic [16:0] sq;
  logic [18:0] kp3;
  logic [31:0] blend_from;
  logic signed [32:0] blend_diff;
  logic [CTB+17:0] phi_sh;
  logic [CTB+17:0] head_sh;
  logic [AW-1:0] phi_ang, head_ang;
  logic signed [53:0] rnd16, rnd15, rnd17;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  assign sum_t   = {1'b0, elapsed_r} + {13'd0, dt_r};
  assign rem2    = {rem_r, 1'b0};
  assign div_bit = (rem2 >= {1'b0, len_r});

  assign rom_idx = ang_r[CTB] ? ((CTB+1)'(ktg_pkg::ROM_N) - {1'b0, ang_r[CTB-1:0]})
                              : {1'b0, ang_r[CTB-1:0]};
  assign sval    = neg_r ? -$signed({1'b0, rom_r}) : $signed({1'b0, rom_r});
  assign hdiff   = 19'sd65536 - 19'(sval);
  assign hsel    = retract_r ? (17'd65536 - h_r) : h_r;
  assign sq      = hi_r ? (17'd65536 - phi_r) : phi_r;
  assign kp3     = {1'b0, kp_r, 1'b0} + {2'b0, kp_r};

  assign phi_sh   = {phi_r, (CTB+1)'(0)};
  assign head_sh  = {heading_r, (CTB+2)'(0)};
  assign phi_ang  = phi_sh[CTB+17:16] + AW'(ktg_pkg::ROM_N);
  assign head_ang = head_sh[CTB+17:16];

  assign blend_from = (ran_r == ktg_pkg::PH_SHIFT) ? toy_r : soy_r;
  assign blend_diff = (ran_r == ktg_pkg::PH_SHIFT)
                    ? ($signed({soy_r[31], soy_r}) - $signed({toy_r[31], toy_r}))
                    : ($signed({toy_r[31], toy_r}) - $signed({soy_r[31], soy_r}));

  assign rnd16 = prod_r + 54'sd32768;
  assign rnd15 = prod_r + 54'sd16384;
  assign rnd17 = prod_r + 54'sd65536;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_QUAD: begin
        mul_a = 34'($signed({1'b0, sq}));
        mul_b = 20'($signed({1'b0, sq}));
      end
      ST_KP3: begin
        mul_a = 34'($signed({1'b0, kp3}));
        mul_b = 20'($signed({1'b0, back_dist_r}));
      end
      ST_MUL1: begin
        if (ran_r == ktg_pkg::PH_KICK) begin
          mul_a = 34'($signed({1'b0, hsel}));
          mul_b = 20'($signed({1'b0, back_dist_r}));
        end else begin
          mul_a = 34'(blend_diff);
          mul_b = 20'($signed({1'b0, h_r}));
        end
      end
      ST_MUL2: begin
        mul_a = 34'($signed({1'b0, hsel}));
        mul_b = 20'($signed({1'b0, kick_h_r}));
      end
      ST_ROTX: begin
        mul_a = 34'(ox_r);
        mul_b = 20'(c_r);
      end
      ST_ROTY: begin
        mul_a = 34'(ox_r);
        mul_b = 20'(s_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_acc && (in_tuser == ktg_pkg::ACT_TICK)) state_nxt = ST_ADD;
      ST_ADD:   state_nxt = ST_CMP;
      ST_CMP:   state_nxt = ST_FRAC;
      ST_FRAC: begin
        if (ran_r == ktg_pkg::PH_SHIFT || ran_r == ktg_pkg::PH_KICK ||
            ran_r == ktg_pkg::PH_RETURN) state_nxt = ST_CHK;
        else state_nxt = ST_OUT;
      end
      ST_CHK: begin
        if (len_r == '0 || num_r >= {8'd0, len_r}) state_nxt = ST_PHI;
        else state_nxt = ST_DIV;
      end
      ST_DIV:   if (cnt_r == 4'd15) state_nxt = ST_PHI;
      ST_PHI:   state_nxt = swing_r ? ST_QUAD : ST_ROM;
      ST_QUAD:  state_nxt = ST_KP;
      ST_KP:    state_nxt = ST_KP3;
      ST_KP3:   state_nxt = ST_SWG;
      ST_SWG:   state_nxt = ST_HEADC;
      ST_ROM:   state_nxt = ST_HCOS;
      ST_HCOS:  state_nxt = ST_MUL1;
      ST_MUL1:  state_nxt = ST_MUL2;
      ST_MUL2:  state_nxt = (ran_r == ktg_pkg::PH_KICK) ? ST_MUL3 : ST_OUT;
      ST_MUL3:  state_nxt = ST_HEADC;
      ST_HEADC: state_nxt = ST_HEADS;
      ST_HEADS: state_nxt = ST_ROTX;
      ST_ROTX:  state_nxt = ST_ROTY;
      ST_ROTY:  state_nxt = ST_ROTZ;
      ST_ROTZ:  state_nxt = ST_OUT;
      ST_OUT:   if (!out_valid_r || out_tready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    rom_r  <= ktg_pkg::QROM[rom_idx];
    neg_r  <= ang_r[CTB+1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      side_sep_r  <= 17'd6554;
      shift_t_r   <= 24'd500000;
      lift_t_r    <= 24'd300000;
      swing_t_r   <= 24'd200000;
      retract_t_r <= 24'd300000;
      return_t_r  <= 24'd500000;
      back_dist_r <= 17'd3277;
      kick_h_r    <= 17'd3277;
      phase_r     <= ktg_pkg::PH_IDLE;
      ran_r       <= ktg_pkg::PH_IDLE;
      elapsed_r   <= '0;
      tox_r       <= '0;
      toy_r       <= '0;
      koy_r       <= '0;
      soy_r       <= '0;
      heading_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_wr_en) begin
        unique case (ktg_pkg::cfg_reg_t'(cfg_index))
          ktg_pkg::CFG_SIDE_SEP:     side_sep_r  <= cfg_data[16:0];
          ktg_pkg::CFG_SHIFT_TIME:   shift_t_r   <= cfg_data;
          ktg_pkg::CFG_LIFT_TIME:    lift_t_r    <= cfg_data;
          ktg_pkg::CFG_SWING_TIME:   swing_t_r   <= cfg_data;
          ktg_pkg::CFG_RETRACT_TIME: retract_t_r <= cfg_data;
          ktg_pkg::CFG_RETURN_TIME:  return_t_r  <= cfg_data;
          ktg_pkg::CFG_BACK_DIST:    back_dist_r <= cfg_data[16:0];
          ktg_pkg::CFG_KICK_HEIGHT:  kick_h_r    <= cfg_data[16:0];
          default: ;
        endcase
      end

      if (state_r == ST_OUT && state_nxt == ST_IDLE) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;

      unique case (state_r)
        ST_IDLE: begin
          if (in_acc && (in_tuser == ktg_pkg::ACT_START)) begin
            tox_r     <= in_tdata[32:1];
            toy_r     <= in_tdata[64:33];
            heading_r <= in_tdata[80:65];
            koy_r     <= in_tdata[0] ? (in_tdata[64:33] + {15'd0, side_sep_r})
                                     : (in_tdata[64:33] - {15'd0, side_sep_r});
            soy_r     <= in_tdata[0] ? (in_tdata[64:33] - {15'd0, side_sep_r})
                                     : (in_tdata[64:33] + {15'd0, side_sep_r});
            phase_r   <= ktg_pkg::PH_SHIFT;
            elapsed_r <= '0;
          end
        end
        ST_ADD: begin
          elapsed_r <= sum_t[32] ? '1 : sum_t[31:0];
          ran_r     <= phase_r;
        end
        ST_CMP: begin
          if (ran_r == ktg_pkg::PH_SHIFT && elapsed_r >= {8'd0, shift_t_r}) begin
            phase_r <= ktg_pkg::PH_KICK;
          end
          if (ran_r == ktg_pkg::PH_RETURN && elapsed_r >= {8'd0, return_t_r}) begin
            phase_r <= ktg_pkg::PH_DONE;
          end
          if (ran_r == ktg_pkg::PH_KICK && elapsed_r >= {6'd0, bcd_r}) begin
            phase_r <= ktg_pkg::PH_RETURN;
          end
        end
        ST_FRAC: begin
          if (phase_r != ran_r) elapsed_r <= '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        dt_r <= in_tdata[100:81];
      end
      ST_ADD: begin
        bc_r  <= {1'b0, lift_t_r} + {1'b0, swing_t_r};
        bcd_r <= {2'b0, lift_t_r} + {2'b0, swing_t_r} + {2'b0, retract_t_r};
        ty_r  <= toy_r;
        kx_r  <= tox_r;
        ky_r  <= koy_r;
        kz_r  <= '0;
      end
      ST_CMP: begin
        lt_b_r  <= elapsed_r < {8'd0, lift_t_r};
        lt_bc_r <= elapsed_r < {7'd0, bc_r};
      end
      ST_FRAC: begin
        if (ran_r == ktg_pkg::PH_SHIFT) begin
          swing_r   <= 1'b0;
          retract_r <= 1'b0;
          num_r     <= elapsed_r;
          len_r     <= shift_t_r;
        end else if (ran_r == ktg_pkg::PH_RETURN) begin
          swing_r   <= 1'b0;
          retract_r <= 1'b0;
          num_r     <= elapsed_r;
          len_r     <= return_t_r;
        end else if (ran_r == ktg_pkg::PH_KICK) begin
          ty_r <= soy_r;
          if (lt_b_r) begin
            swing_r   <= 1'b0;
            retract_r <= 1'b0;
            num_r     <= elapsed_r;
            len_r     <= lift_t_r;
          end else if (lt_bc_r) begin
            swing_r   <= 1'b1;
            retract_r <= 1'b0;
            num_r     <= elapsed_r - {8'd0, lift_t_r};
            len_r     <= swing_t_r;
          end else begin
            swing_r   <= 1'b0;
            retract_r <= 1'b1;
            num_r     <= elapsed_r - {7'd0, bc_r};
            len_r     <= retract_t_r;
          end
        end
      end
      ST_CHK: begin
        phi_r <= (len_r == '0 || num_r >= {8'd0, len_r}) ? 17'd65536 : 17'd0;
        rem_r <= num_r[23:0];
        cnt_r <= '0;
      end
      ST_DIV: begin
        rem_r <= div_bit ? 24'(rem2 - {1'b0, len_r}) : rem2[23:0];
        phi_r <= {phi_r[15:0], div_bit};
        cnt_r <= cnt_r + 4'd1;
      end
      ST_PHI: begin
        ang_r <= phi_ang;
        hi_r  <= phi_r[16] | phi_r[15];
      end
      ST_KP: begin
        kp_r <= hi_r ? (17'd65536 - 17'(rnd15[32:15])) : 17'(rnd15[32:15]);
      end
      ST_SWG: begin
        ox_r  <= 18'($signed(rnd17[34:17])) - $signed({1'b0, back_dist_r});
        kz_r  <= kick_h_r;
        ang_r <= head_ang + AW'(ktg_pkg::ROM_N);
      end
      ST_HCOS: begin
        h_r <= 17'(hdiff[17:1]);
      end
      ST_MUL2: begin
        if (ran_r == ktg_pkg::PH_KICK) begin
          if (retract_r) ox_r <= $signed({1'b0, rnd17[33:17]});
          else ox_r <= -$signed(rnd16[33:16]);
        end else begin
          ty_r <= blend_from + rnd16[47:16];
        end
      end
      ST_MUL3: begin
        kz_r  <= rnd16[32:16];
        ang_r <= head_ang + AW'(ktg_pkg::ROM_N);
      end
      ST_HEADC: begin
        ang_r <= head_ang;
      end
      ST_HEADS: begin
        c_r <= sval;
      end
      ST_ROTX: begin
        s_r <= sval;
      end
      ST_ROTY: begin
        kx_r <= tox_r + rnd16[47:16];
      end
      ST_ROTZ: begin
        ky_r <= koy_r + rnd16[47:16];
      end
      ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_user_r <= ran_r;
          out_data_r <= {6'd0, kz_r, ky_r, kx_r, soy_r, tox_r, ty_r, tox_r,
                         (ran_r == ktg_pkg::PH_SHIFT || ran_r == ktg_pkg::PH_KICK ||
                          ran_r == ktg_pkg::PH_RETURN)};
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== tb/sv/tb_kick_trajectory_generator_core.sv =====
// Testbench: kick trajectory generator core, checked beat by beat against a local trajectory predictor.
`timescale 1ns / 100ps

module tb_kick_trajectory_generator_core;

  localparam int LIMIT_CYCLES = 3000000;
  localparam int SETTLE = 80;
  localparam int CTB = ktg_pkg::COS_TABLE_BITS;
  localparam int N = 1 << CTB;

  typedef struct {
    logic        active;
    logic [2:0]  ph;
    logic [31:0] tx, ty, sx, sy, kx, ky;
    logic [16:0] kz;
  } traj_t;

  typedef struct {
    logic        act;
    logic        lk;
    logic [31:0] x, y;
    logic [15:0] yaw;
    logic [19:0] dt;
    bit          lit;
    traj_t       want;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [ktg_pkg::IN_DATA_W-1:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [ktg_pkg::OUT_DATA_W-1:0] out_tdata;
  logic [2:0] out_tuser;
  logic cfg_wr_en = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [ktg_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  kick_trajectory_generator_core u_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state and register copy
  int unsigned sine_q16 [0:N];
  logic [31:0] regs [0:7];
  ktg_pkg::phase_t cur_ph;
  logic [31:0] elap, org_x, org_y, kick_oy, sup_oy;
  logic [15:0] head;

  traj_t expected_q[$];
  int errors = 0;
  int cycles = 0;
  int sent = 0;
  int burst_left = 0;

  function automatic int unsigned sine_entry(int k);
    longint unsigned x, x2, term;
    longint sum, r;
    x = (longint'(k) * 64'd1686629713) >> CTB;
    x2 = (x * x) >> 30;
    term = x;
    sum = longint'(x);
    for (int n = 1; n <= 7; n++) begin
      term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    r = (sum + 8192) / 16384;
    if (r > 65536) r = 65536;
    return int'(r);
  endfunction

  function automatic longint sin_of(int unsigned a);
    int unsigned q, r;
    a = a & (4 * N - 1);
    q = a >> CTB;
    r = a & (N - 1);
    case (q)
      0: return sine_q16[r];
      1: return sine_q16[N - r];
      2: return -longint'(sine_q16[r]);
      default: return -longint'(sine_q16[N - r]);
    endcase
  endfunction

  function automatic longint unsigned raised_cos(longint unsigned phi);
    int unsigned a;
    a = int'((phi << (CTB + 1)) >> 16);
    return longint'(65536 - sin_of(a + N)) >> 1;
  endfunction

  function automatic longint unsigned frac_of(longint unsigned t, longint unsigned len);
    if (len == 0 || t >= len) return 65536;
    return (t << 16) / len;
  endfunction

  function automatic logic [31:0] blend(logic [31:0] from, logic [31:0] to,
                                        longint unsigned h);
    longint diff;
    diff = longint'($signed(to)) - longint'($signed(from));
    return from + 32'((diff * longint'(h) + 32768) >>> 16);
  endfunction

  function automatic bit traj_step(logic act, logic lk, logic [31:0] x, logic [31:0] y,
                                   logic [15:0] yaw, logic [19:0] dt, output traj_t r);
    longint unsigned t, xk, zk, b, bc, bcd, h, phi, kp, d, g;
    longint ox, c, s;
    int unsigned a;
    if (act == ktg_pkg::ACT_START) begin
      org_x = x;
      org_y = y;
      head = yaw;
      kick_oy = lk ? y + regs[ktg_pkg::CFG_SIDE_SEP] : y - regs[ktg_pkg::CFG_SIDE_SEP];
      sup_oy = lk ? y - regs[ktg_pkg::CFG_SIDE_SEP] : y + regs[ktg_pkg::CFG_SIDE_SEP];
      cur_ph = ktg_pkg::PH_SHIFT;
      elap = 0;
      return 0;
    end
    t = longint'(elap) + dt;
    elap = t > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : 32'(t);
    t = elap;
    r.active = 1'b0;
    r.ph = cur_ph;
    r.tx = org_x;
    r.ty = org_y;
    r.sx = org_x;
    r.sy = sup_oy;
    r.kx = org_x;
    r.ky = kick_oy;
    r.kz = '0;
    case (cur_ph)
      ktg_pkg::PH_SHIFT: begin
        r.active = 1'b1;
        r.ty = blend(org_y, sup_oy, raised_cos(frac_of(t, regs[ktg_pkg::CFG_SHIFT_TIME])));
        if (t >= regs[ktg_pkg::CFG_SHIFT_TIME]) begin
          elap = 0;
          cur_ph = ktg_pkg::PH_KICK;
        end
      end
      ktg_pkg::PH_KICK: begin
        xk = regs[ktg_pkg::CFG_BACK_DIST];
        zk = regs[ktg_pkg::CFG_KICK_HEIGHT];
        b = regs[ktg_pkg::CFG_LIFT_TIME];
        bc = b + regs[ktg_pkg::CFG_SWING_TIME];
        bcd = bc + regs[ktg_pkg::CFG_RETRACT_TIME];
        r.active = 1'b1;
        r.ty = sup_oy;
        if (t < b) begin
          h = raised_cos(frac_of(t, regs[ktg_pkg::CFG_LIFT_TIME]));
          ox = -longint'((h * xk + 32768) >> 16);
          r.kz = 17'((h * zk + 32768) >> 16);
        end else if (t < bc) begin
          phi = frac_of(t - b, regs[ktg_pkg::CFG_SWING_TIME]);
          if (phi < 32768) kp = (phi * phi + 16384) >> 15;
          else begin
            d = 65536 - phi;
            kp = 65536 - ((d * d + 16384) >> 15);
          end
          ox = -longint'(xk) + longint'((kp * 3 * xk + 65536) >> 17);
          r.kz = 17'(zk);
        end else begin
          h = raised_cos(frac_of(t - bc, regs[ktg_pkg::CFG_RETRACT_TIME]));
          g = 65536 - h;
          ox = longint'((g * xk + 65536) >> 17);
          r.kz = 17'((g * zk + 32768) >> 16);
        end
        a = int'(head) >> 4;
        c = sin_of(a + N);
        s = sin_of(a);
        r.kx = org_x + 32'((ox * c + 32768) >>> 16);
        r.ky = kick_oy + 32'((ox * s + 32768) >>> 16);
        if (t >= bcd) begin
          elap = 0;
          cur_ph = ktg_pkg::PH_RETURN;
        end
      end
      ktg_pkg::PH_RETURN: begin
        r.active = 1'b1;
        r.ty = blend(sup_oy, org_y, raised_cos(frac_of(t, regs[ktg_pkg::CFG_RETURN_TIME])));
        if (t >= regs[ktg_pkg::CFG_RETURN_TIME]) begin
          elap = 0;
          cur_ph = ktg_pkg::PH_DONE;
        end
      end
      default: ;
    endcase
    return 1;
  endfunction

  task automatic write_reg(ktg_pkg::cfg_reg_t idx, logic [23:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    regs[idx] = (idx == ktg_pkg::CFG_SIDE_SEP || idx == ktg_pkg::CFG_BACK_DIST ||
                 idx == ktg_pkg::CFG_KICK_HEIGHT) ? val & 24'h1FFFF : val;
  endtask

  task automatic wait_drained();
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic send_beat(logic act, logic lk, logic [31:0] x, logic [31:0] y,
                           logic [15:0] yaw, logic [19:0] dt, bit lit, traj_t want);
    traj_t r;
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
      @(negedge clk);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end else begin
      @(negedge clk);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser <= act;
    in_tdata <= {3'b0, dt, yaw, y, x, lk};
    do @(posedge clk); while (!in_tready);
    if (traj_step(act, lk, x, y, yaw, dt, r)) begin
      if (lit) expected_q.push_back(want);
      else expected_q.push_back(r);
    end
    sent++;
  endtask

  task automatic start_beat(logic lk, logic [31:0] x, logic [31:0] y, logic [15:0] yaw);
    traj_t nul;
    nul = '{default: '0};
    send_beat(ktg_pkg::ACT_START, lk, x, y, yaw, 20'($urandom), 0, nul);
  endtask

  task automatic tick_beat(logic [19:0] dt);
    traj_t nul;
    nul = '{default: '0};
    send_beat(ktg_pkg::ACT_TICK, 1'($urandom), $urandom, $urandom, 16'($urandom), dt, 0, nul);
  endtask

  // receiver: stall pattern steps in turn through always, half, quarter and nine-tenths ready
  always @(negedge clk) begin
    case ((cycles / 64) % 4)
      0: out_tready <= 1'b1;
      1: out_tready <= 1'($urandom);
      2: out_tready <= ($urandom_range(0, 3) == 0);
      default: out_tready <= ($urandom_range(0, 9) != 0);
    endcase
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    traj_t w, g;
    if (rst_n && out_tvalid && out_tready) begin
      g.active = out_tdata[0];
      g.ph = out_tuser;
      g.tx = out_tdata[32:1];
      g.ty = out_tdata[64:33];
      g.sx = out_tdata[96:65];
      g.sy = out_tdata[128:97];
      g.kx = out_tdata[160:129];
      g.ky = out_tdata[192:161];
      g.kz = out_tdata[209:193];
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t unexpected beat: got phase %0d", $time, g.ph);
      end else begin
        w = expected_q.pop_front();
        if (g.active !== w.active || g.ph !== w.ph || g.tx !== w.tx || g.ty !== w.ty ||
            g.sx !== w.sx || g.sy !== w.sy || g.kx !== w.kx || g.ky !== w.ky ||
            g.kz !== w.kz) begin
          errors++;
          $display("%0t mismatch exp act=%0d ph=%0d t=%h,%h s=%h,%h k=%h,%h,%h", $time,
                   w.active, w.ph, w.tx, w.ty, w.sx, w.sy, w.kx, w.ky, w.kz);
          $display("%0t          got act=%0d ph=%0d t=%h,%h s=%h,%h k=%h,%h,%h", $time,
                   g.active, g.ph, g.tx, g.ty, g.sx, g.sy, g.kx, g.ky, g.kz);
        end
      end
    end
  end

  initial begin
    row_t rows[$];
    traj_t z;
    int target, tmax;
    logic [19:0] dt;
    for (int k = 0; k <= N; k++) sine_q16[k] = sine_entry(k);
    regs = '{6554, 500000, 300000, 200000, 300000, 500000, 3277, 3277};
    cur_ph = ktg_pkg::PH_IDLE;
    {elap, org_x, org_y, kick_oy, sup_oy, head} = '0;
    z = '{default: '0};

    rows.push_back('{ktg_pkg::ACT_TICK, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 20'd0,
                     1, z});
    rows.push_back('{ktg_pkg::ACT_TICK, 0, 0, 0, 0, 20'd1000000, 1, z});
    rows.push_back('{ktg_pkg::ACT_START, 1, 32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF, 20'hFFFFF,
                     0, z});
    for (int i = 0; i < 4; i++)
      rows.push_back('{ktg_pkg::ACT_TICK, 0, 0, 0, 0, 20'd1000000, 0, z});
    rows.push_back('{ktg_pkg::ACT_START, 0, 32'h8000_0000, 32'h7FFF_FFFF, 16'h0000, 20'd0,
                     0, z});
    for (int i = 0; i < 6; i++)
      rows.push_back('{ktg_pkg::ACT_TICK, 0, 0, 0, 0, 20'd150000, 0, z});
    rows.push_back('{ktg_pkg::ACT_START, 1, 32'h0001_0000, 32'hFFFF_0000, 16'h4000, 20'd0,
                     0, z});
    for (int i = 0; i < 10; i++)
      rows.push_back('{ktg_pkg::ACT_TICK, 0, 0, 0, 0, 20'd130000, 0, z});

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (rows[i])
      send_beat(rows[i].act, rows[i].lk, rows[i].x, rows[i].y, rows[i].yaw, rows[i].dt,
                rows[i].lit, rows[i].want);

    target = sent;
    for (int p = 0; p < 8; p++) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      wait_drained();
      case (p)
        0: begin
          write_reg(ktg_pkg::CFG_SIDE_SEP, 24'd65536);
          for (int i = ktg_pkg::CFG_SHIFT_TIME; i <= ktg_pkg::CFG_RETURN_TIME; i++)
            write_reg(ktg_pkg::cfg_reg_t'(i), 24'hFFFFFF);
          write_reg(ktg_pkg::CFG_BACK_DIST, 24'd65536);
          write_reg(ktg_pkg::CFG_KICK_HEIGHT, 24'd65536);
        end
        1: begin
          write_reg(ktg_pkg::CFG_SIDE_SEP, 24'd0);
          for (int i = ktg_pkg::CFG_SHIFT_TIME; i <= ktg_pkg::CFG_RETURN_TIME; i++)
            write_reg(ktg_pkg::cfg_reg_t'(i), 24'd1);
          write_reg(ktg_pkg::CFG_BACK_DIST, 24'd0);
          write_reg(ktg_pkg::CFG_KICK_HEIGHT, 24'd0);
        end
        2: begin
          write_reg(ktg_pkg::CFG_LIFT_TIME, 24'd0);
          write_reg(ktg_pkg::CFG_SWING_TIME, 24'd0);
          write_reg(ktg_pkg::CFG_RETRACT_TIME, 24'd0);
          write_reg(ktg_pkg::CFG_SHIFT_TIME, 24'd0);
          write_reg(ktg_pkg::CFG_RETURN_TIME, 24'd0);
          write_reg(ktg_pkg::CFG_BACK_DIST, 24'd131071);
          write_reg(ktg_pkg::CFG_KICK_HEIGHT, 24'd131071);
        end
        default: begin
          write_reg(ktg_pkg::CFG_SIDE_SEP, 24'($urandom_range(0, 131071)));
          for (int i = ktg_pkg::CFG_SHIFT_TIME; i <= ktg_pkg::CFG_RETURN_TIME; i++)
            write_reg(ktg_pkg::cfg_reg_t'(i), 24'($urandom_range(0, 20) == 0 ? 0 :
                                                   $urandom_range(1, 40000)));
          write_reg(ktg_pkg::CFG_BACK_DIST, 24'($urandom_range(0, 131071)));
          write_reg(ktg_pkg::CFG_KICK_HEIGHT, 24'($urandom_range(0, 131071)));
        end
      endcase
      tmax = 1;
      for (int i = ktg_pkg::CFG_SHIFT_TIME; i <= ktg_pkg::CFG_RETURN_TIME; i++)
        if (regs[i] > tmax) tmax = regs[i];
      tmax = tmax / 3 + 1;
      if (tmax > 1000000) tmax = 1000000;
      target += (p < 3) ? 100 : 180;
      while (sent < target) begin
        if ($urandom_range(0, 9) == 0) begin
          tick_beat(20'($urandom_range(0, 1000000)));
        end else begin
          case ($urandom_range(0, 5))
            0: start_beat(1'($urandom), 32'h7FFF_FFFF ^ 32'($urandom_range(0, 1) << 31),
                          32'($urandom_range(0, 1) << 31), 16'($urandom));
            default: start_beat(1'($urandom), $urandom, $urandom, 16'($urandom));
          endcase
          while (cur_ph != ktg_pkg::PH_DONE && sent < target + 40) begin
            if ($urandom_range(0, 60) == 0) break;
            case ($urandom_range(0, 19))
              0: dt = 20'd0;
              1: dt = 20'($urandom_range(0, 1000000));
              default: dt = 20'($urandom_range(0, tmax));
            endcase
            tick_beat(dt);
          end
          if ($urandom_range(0, 2) == 0) tick_beat(20'($urandom_range(0, 1000000)));
        end
      end
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    wait_drained();
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
